@@ src/mdu_pkg.sv @@
// shared types and constants of the multiply/divide register unit
// no dependencies; used by mdu_arith, multiply_divide_register_unit, mdu_reply_checker and testbench
package mdu_pkg;

	// register map
	localparam logic [15:0] ADDR_MUL_A  = 16'h4202;
	localparam logic [15:0] ADDR_MUL_B  = 16'h4203;
	localparam logic [15:0] ADDR_DIV_LO = 16'h4204;
	localparam logic [15:0] ADDR_DIV_HI = 16'h4205;
	localparam logic [15:0] ADDR_DIV_B  = 16'h4206;
	localparam logic [15:0] ADDR_RD_QUO = 16'h4214;
	localparam logic [15:0] ADDR_RD_REM = 16'h4216;
	localparam logic [15:0] ADDR_RD_END = 16'h4217;

	// quotient reported for a zero divisor
	localparam logic [15:0] DIV0_QUOT = 16'hFFFF;

	// datapath sizes
	localparam int ALU_W     = 17;
	localparam int CNT_W     = 4;
	localparam int MUL_STEPS = 8;
	localparam int DIV_STEPS = 16;

	// access kind carried in tuser
	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV,
		ST_REPLY
	} state_t;

	// control of the shared adder
	typedef struct packed {
		logic sub;
	} alu_ctrl_t;

endpackage

@@ src/mdu_arith.sv @@
// shared add/subtract unit used for every multiply and divide step
// depends on mdu_pkg
module mdu_arith (
	input  logic [mdu_pkg::ALU_W-1:0] a,
	input  logic [mdu_pkg::ALU_W-1:0] b,
	input  mdu_pkg::alu_ctrl_t        ctrl,
	output logic [mdu_pkg::ALU_W-1:0] sum
);

	// one adder, b inverted for subtract; the top bit is the borrow on subtract
	always_comb begin
		if (ctrl.sub) begin
			sum = a - b;
		end else begin
			sum = a + b;
		end
	end

endmodule

@@ src/multiply_divide_register_unit.sv @@
// top level of the multiply/divide register unit: request decode, sequencer, registers
// depends on mdu_pkg and mdu_arith
//
// Each request is one bus access (tuser = read/write, tdata = address and write byte)
// and yields exactly one reply (tdata = read byte, tuser = hit). Requests are taken one
// at a time. A plain register access passes through the decode and reply states before
// its reply is offered. A write to 0x4203 runs 8 shift-and-add steps, and a write to
// 0x4206 with a nonzero divisor runs 16 restoring division steps (one quotient bit per
// cycle). All steps run through one 17-bit adder/subtractor. A new request is taken as
// soon as the previous one has reached the output register, even if the reply there has
// not been taken yet; a stalled reply adds the cycles of the stall.
module multiply_divide_register_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [15:0] reg_address, [23:16] write_data
	input  logic        s_axis_tuser,  // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] read_data
	output logic        m_axis_tuser   // [0] hit
);

	mdu_pkg::state_t state_q, state_d;

	// captured request
	logic        req_op_q;
	logic [15:0] req_addr_q;
	logic [7:0]  req_data_q;

	// architectural registers
	logic [7:0]  mcand_q;
	logic [15:0] dividend_q;
	logic [15:0] quotient_q;
	logic [15:0] rem_q;

	// iteration registers
	logic [15:0]              work_q;
	logic [7:0]               part_q;
	logic [7:0]               opnd_q;
	logic [mdu_pkg::CNT_W-1:0] cnt_q;

	// reply waiting for the output register
	logic [7:0] res_data_q;
	logic       res_hit_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_hit_q;

	logic                       accept;
	logic                       out_free;
	logic                       last_step;
	logic [mdu_pkg::ALU_W-1:0]  alu_a, alu_b, alu_sum;
	mdu_pkg::alu_ctrl_t         alu_ctrl;
	logic                       borrow;
	logic                       qbit;
	logic [7:0]                 part_next;
	logic [15:0]                quo_next;
	logic                       is_write;
	logic                       rd_hit;
	logic [15:0]                rd_word;
	logic [7:0]                 rd_byte;
	logic                       wr_hit;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign last_step = (cnt_q == '0);

	// operand select for the shared adder
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		alu_ctrl = '{sub: 1'b0};
		unique case (state_q)
			mdu_pkg::ST_MUL: begin
				alu_a = {work_q, 1'b0};
				alu_b = {9'b0, (opnd_q[7] ? mcand_q : 8'h00)};
			end
			mdu_pkg::ST_DIV: begin
				alu_a    = {8'b0, part_q, work_q[15]};
				alu_b    = {9'b0, opnd_q};
				alu_ctrl = '{sub: 1'b1};
			end
			default: begin
			end
		endcase
	end

	mdu_arith u_arith (
		.a    (alu_a),
		.b    (alu_b),
		.ctrl (alu_ctrl),
		.sum  (alu_sum)
	);

	// restoring division step results
	assign borrow    = alu_sum[mdu_pkg::ALU_W-1];
	assign qbit      = !borrow;
	assign part_next = borrow ? alu_a[7:0] : alu_sum[7:0];
	assign quo_next  = {work_q[14:0], qbit};

	// address decode of the captured request
	always_comb begin
		is_write = (req_op_q == mdu_pkg::OP_WRITE);
		rd_hit   = (req_addr_q >= mdu_pkg::ADDR_RD_QUO) && (req_addr_q <= mdu_pkg::ADDR_RD_END);
		rd_word  = (req_addr_q < mdu_pkg::ADDR_RD_REM) ? quotient_q : rem_q;
		rd_byte  = req_addr_q[0] ? rd_word[15:8] : rd_word[7:0];
		wr_hit   = (req_addr_q == mdu_pkg::ADDR_MUL_A) || (req_addr_q == mdu_pkg::ADDR_MUL_B)
			|| (req_addr_q == mdu_pkg::ADDR_DIV_LO) || (req_addr_q == mdu_pkg::ADDR_DIV_HI)
			|| (req_addr_q == mdu_pkg::ADDR_DIV_B);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ready
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			mdu_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = mdu_pkg::ST_DECODE;
				end
			end
			mdu_pkg::ST_DECODE: begin
				priority if (is_write && req_addr_q == mdu_pkg::ADDR_MUL_B) begin
					state_d = mdu_pkg::ST_MUL;
				end else if (is_write && req_addr_q == mdu_pkg::ADDR_DIV_B
					&& req_data_q != 8'h00) begin
					state_d = mdu_pkg::ST_DIV;
				end else begin
					state_d = mdu_pkg::ST_REPLY;
				end
			end
			mdu_pkg::ST_MUL, mdu_pkg::ST_DIV: begin
				if (last_step) begin
					state_d = mdu_pkg::ST_REPLY;
				end
			end
			mdu_pkg::ST_REPLY: begin
				if (out_free) begin
					state_d = mdu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mdu_pkg::ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q   <= s_axis_tuser;
			req_addr_q <= s_axis_tdata[15:0];
			req_data_q <= s_axis_tdata[23:16];
		end
	end

	// architectural registers and iteration datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q    <= '0;
			dividend_q <= '0;
			quotient_q <= '0;
			rem_q      <= '0;
		end else begin
			unique case (state_q)
				mdu_pkg::ST_DECODE: begin
					if (is_write) begin
						unique case (req_addr_q)
							mdu_pkg::ADDR_MUL_A:  mcand_q <= req_data_q;
							mdu_pkg::ADDR_DIV_LO: dividend_q[7:0] <= req_data_q;
							mdu_pkg::ADDR_DIV_HI: dividend_q[15:8] <= req_data_q;
							mdu_pkg::ADDR_DIV_B: begin
								if (req_data_q == 8'h00) begin
									quotient_q <= mdu_pkg::DIV0_QUOT;
									rem_q      <= dividend_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				mdu_pkg::ST_MUL: begin
					if (last_step) begin
						rem_q <= alu_sum[15:0];
					end
				end
				mdu_pkg::ST_DIV: begin
					if (last_step) begin
						quotient_q <= quo_next;
						rem_q      <= {8'h00, part_next};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// iteration registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mdu_pkg::ST_DECODE: begin
				part_q <= '0;
				opnd_q <= req_data_q;
				if (req_addr_q == mdu_pkg::ADDR_MUL_B) begin
					work_q <= '0;
					cnt_q  <= mdu_pkg::CNT_W'(mdu_pkg::MUL_STEPS - 1);
				end else begin
					work_q <= dividend_q;
					cnt_q  <= mdu_pkg::CNT_W'(mdu_pkg::DIV_STEPS - 1);
				end
			end
			mdu_pkg::ST_MUL: begin
				work_q <= alu_sum[15:0];
				opnd_q <= {opnd_q[6:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
			end
			mdu_pkg::ST_DIV: begin
				work_q <= quo_next;
				part_q <= part_next;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// pending reply, decided at decode
	always_ff @(posedge clk) begin
		if (state_q == mdu_pkg::ST_DECODE) begin
			if (is_write) begin
				res_data_q <= 8'h00;
				res_hit_q  <= wr_hit;
			end else begin
				res_data_q <= rd_hit ? rd_byte : 8'h00;
				res_hit_q  <= rd_hit;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mdu_pkg::ST_REPLY && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdu_pkg::ST_REPLY && out_free) begin
			out_data_q <= res_data_q;
			out_hit_q  <= res_hit_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_hit_q;

	// an accepted request is decoded next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mdu_pkg::ST_DECODE)
		else $error("accepted request not decoded");

	// multiply never runs more than its step count
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdu_pkg::ST_MUL) |-> (cnt_q < mdu_pkg::CNT_W'(mdu_pkg::MUL_STEPS)))
		else $error("multiply step count out of range");

	// a reply moved to a free output register is offered next cycle
	a_reply_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mdu_pkg::ST_REPLY && out_free) |=> m_axis_tvalid)
		else $error("reply not offered");

	// a miss never returns data; a write also replies with zero data, which this check does not cover
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
		else $error("nonzero data on a miss");

endmodule

@@ tb/sv/mdu_reply_checker.sv @@
// reply checker for the multiply/divide register unit: watches both streams,
// predicts each reply from its own copy of the register state and compares
// depends on mdu_pkg for the register map and the access kind
module mdu_reply_checker
	import mdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [15:0] reg_address, [23:16] write_data
	input  logic        s_axis_tuser,  // [0] operation
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // [7:0] read_data
	input  logic        m_axis_tuser,  // [0] hit
	output int          errors,
	output int          pending,
	output int          replies_seen
);

	typedef struct packed {
		logic [7:0] read_data;
		logic       hit;
	} reply_t;

	// shadow copy of the unit's registers
	logic [7:0]  mul_operand;
	logic [15:0] div_operand;
	logic [15:0] quo_reg;
	logic [15:0] rem_reg;

	// replies owed for requests already taken, oldest first
	reply_t reply_q[$];
	reply_t predicted;
	reply_t owed;
	int     fail_count;
	int     checked_count;

	// apply one bus access to the shadow registers and work out its reply
	task automatic predict_access(input op_t op, input logic [15:0] addr,
			input logic [7:0] data, output reply_t r);
		logic [15:0] word;
		r = '0;
		if (op == OP_WRITE) begin
			r.hit = 1'b1;
			case (addr)
				ADDR_MUL_A: mul_operand = data;
				ADDR_MUL_B: rem_reg = 16'(mul_operand) * 16'(data);
				ADDR_DIV_LO: div_operand[7:0] = data;
				ADDR_DIV_HI: div_operand[15:8] = data;
				ADDR_DIV_B: begin
					// divide by zero saturates the quotient and keeps the dividend
					if (data == 8'd0) begin
						quo_reg = DIV0_QUOT;
						rem_reg = div_operand;
					end else begin
						quo_reg = div_operand / 16'(data);
						rem_reg = div_operand % 16'(data);
					end
				end
				default: r.hit = 1'b0;
			endcase
		end else if (addr >= ADDR_RD_QUO && addr <= ADDR_RD_END) begin
			word = (addr < ADDR_RD_REM) ? quo_reg : rem_reg;
			r.read_data = addr[0] ? word[15:8] : word[7:0];
			r.hit = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_operand = '0;
			div_operand = '0;
			quo_reg = '0;
			rem_reg = '0;
			reply_q.delete();
			fail_count = 0;
			checked_count = 0;
			errors <= 0;
			pending <= 0;
			replies_seen <= 0;
		end else begin
			// a reply leaving on this edge belongs to an earlier request
			if (m_axis_tvalid && m_axis_tready) begin
				checked_count++;
				if (reply_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("reply %0d with no request pending: read_data %02h hit %0b",
							checked_count, m_axis_tdata, m_axis_tuser);
				end else begin
					owed = reply_q.pop_front();
					if (m_axis_tdata !== owed.read_data || m_axis_tuser !== owed.hit) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"reply %0d: expected read_data %02h hit %0b, ",
								"got read_data %02h hit %0b"},
								checked_count, owed.read_data, owed.hit,
								m_axis_tdata, m_axis_tuser);
					end
				end
			end
			// predict the reply of a request taken on this edge
			if (s_axis_tvalid && s_axis_tready) begin
				predict_access(op_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[23:16],
					predicted);
				reply_q.push_back(predicted);
			end
			errors <= fail_count;
			pending <= reply_q.size();
			replies_seen <= checked_count;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// top of the multiply/divide register unit testbench: clock, reset, request stimulus,
// reply back-pressure, watchdog and verdict
// depends on mdu_pkg, multiply_divide_register_unit and mdu_reply_checker
module testbench;
	import mdu_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS    = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [15:0] reg_address, [23:16] write_data
	logic        s_axis_tuser = 1'b0; // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [7:0] read_data
	logic        m_axis_tuser;        // [0] hit

	int errors;
	int pending;
	int replies_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int n_sent = 0;
	int n_reads = 0;
	int n_writes = 0;
	int n_div_zero = 0;
	int n_unmapped = 0;

	always #5 clk = ~clk;

	multiply_divide_register_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	mdu_reply_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.replies_seen  (replies_seen)
	);

	// reply back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one request, with a random gap first, and wait until it is taken
	task automatic put_access(input op_t op, input logic [15:0] addr, input logic [7:0] data);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {data, addr};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
		if (op == OP_WRITE) begin
			n_writes++;
			if (addr == ADDR_DIV_B && data == 8'd0)
				n_div_zero++;
		end else begin
			n_reads++;
		end
		if (!(addr >= ADDR_MUL_A && addr <= ADDR_DIV_B) &&
				!(addr >= ADDR_RD_QUO && addr <= ADDR_RD_END))
			n_unmapped++;
	endtask

	// stop offering requests until every reply has been taken
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// multiply, then read the product back
	task automatic mul_sequence();
		if ($urandom_range(9) != 0)
			put_access(OP_WRITE, ADDR_MUL_A, 8'($urandom));
		put_access(OP_WRITE, ADDR_MUL_B, 8'($urandom));
		put_access(OP_READ, ADDR_RD_REM, 8'($urandom));
		put_access(OP_READ, ADDR_RD_END, 8'($urandom));
	endtask

	// load a dividend, divide, then read quotient and remainder
	task automatic div_sequence();
		logic [7:0] divisor;
		divisor = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
		if ($urandom_range(7) != 0)
			put_access(OP_WRITE, ADDR_DIV_LO, 8'($urandom));
		if ($urandom_range(7) != 0)
			put_access(OP_WRITE, ADDR_DIV_HI, 8'($urandom));
		put_access(OP_WRITE, ADDR_DIV_B, divisor);
		for (int k = 0; k < 4; k++)
			put_access(OP_READ, 16'(ADDR_RD_QUO + k), 8'($urandom));
	endtask

	// a lone access anywhere in the bank or near the register map
	task automatic stray_access();
		logic [15:0] addr;
		addr = ($urandom_range(1) == 0) ? 16'($urandom) : 16'(16'h4200 + $urandom_range(31));
		put_access(op_t'($urandom_range(1)), addr, 8'($urandom));
	endtask

	initial begin
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, product of the largest operands
		for (int k = 0; k < 4; k++)
			put_access(OP_READ, 16'(ADDR_RD_QUO + k), 8'hFF);
		put_access(OP_WRITE, ADDR_MUL_A, 8'hFF);
		put_access(OP_WRITE, ADDR_MUL_B, 8'hFF);
		put_access(OP_READ, ADDR_RD_REM, 8'h00);
		put_access(OP_READ, ADDR_RD_END, 8'h00);
		// division by zero of the largest dividend
		put_access(OP_WRITE, ADDR_DIV_LO, 8'hFF);
		put_access(OP_WRITE, ADDR_DIV_HI, 8'hFF);
		put_access(OP_WRITE, ADDR_DIV_B, 8'h00);
		for (int k = 0; k < 4; k++)
			put_access(OP_READ, 16'(ADDR_RD_QUO + k), 8'h00);
		// multiply leaves the quotient alone
		put_access(OP_WRITE, ADDR_DIV_B, 8'hFF);
		put_access(OP_WRITE, ADDR_MUL_B, 8'h00);
		put_access(OP_READ, ADDR_RD_QUO, 8'h00);
		put_access(OP_READ, 16'(ADDR_RD_QUO + 1), 8'h00);
		// wrong direction and unmapped addresses
		put_access(OP_READ, ADDR_DIV_B, 8'h00);
		put_access(OP_WRITE, ADDR_RD_END, 8'hFF);
		put_access(OP_READ, ADDR_RD_END, 8'h00);
		put_access(OP_WRITE, 16'h0000, 8'hFF);
		put_access(OP_READ, 16'hFFFF, 8'hFF);
		put_access(OP_WRITE, 16'hFFFF, 8'h00);
		wait_idle();

		// random: four pacing phases, each drained before the next
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			r = n_sent + PHASE_ITEMS;
			while (n_sent < r) begin
				case ($urandom_range(9))
					0, 1, 2, 3: mul_sequence();
					4, 5, 6, 7: div_sequence();
					default: stray_access();
				endcase
			end
			wait_idle();
		end

		stall_pct = 0;
		repeat (30) @(posedge clk);
		$display("covered %0d requests: %0d reads, %0d writes, %0d divides by zero, %0d unmapped",
			n_sent, n_reads, n_writes, n_div_zero, n_unmapped);
		$display("%0d replies checked over four request/reply pacing phases", replies_seen);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/mdu_pkg.sv
src/mdu_arith.sv
src/multiply_divide_register_unit.sv
tb/sv/mdu_reply_checker.sv
tb/sv/testbench.sv
